// ===== rtl/mcc_pkg.sv =====
// shared types and constants of the concordance counter
`timescale 1ns / 1ps
package mcc_pkg;
    localparam int KIND_W     = 2;
    localparam int PIDX_W     = 10;
    localparam int CIDX_W     = 3;
    localparam int VAL_W      = 32;
    localparam int LVL_W      = 3;
    localparam int CNT_W      = 10;
    localparam int PC_W       = 11;
    localparam int DC_W       = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;

    typedef logic [KIND_W-1:0] t_kind;
    localparam t_kind KIND_LOAD    = 2'd0;
    localparam t_kind KIND_COMPUTE = 2'd1;
    localparam t_kind KIND_QUERY   = 2'd2;
    localparam t_kind KIND_UNUSED  = 2'd3;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx REG_POINT_COUNT = 1'd0;
    localparam t_cfg_idx REG_DIM_COUNT   = 1'd1;

    localparam logic [PC_W-1:0] POINT_COUNT_RST = 11'd1024;
    localparam logic [DC_W-1:0] DIM_COUNT_RST   = 4'd8;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLR,
        S_ROW_RD,
        S_J_RD,
        S_J_CMP,
        S_BUMP_WR,
        S_ROW_WR,
        S_Q_RD,
        S_Q_ACC,
        S_DONE
    } t_state;
endpackage

// ===== rtl/mcc_in_if.sv =====
// input channel of the concordance counter
`timescale 1ns / 1ps
interface mcc_in_if
    import mcc_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [KIND_W-1:0]        kind;
    logic [PIDX_W-1:0]        point_index;
    logic [CIDX_W-1:0]        coord_index;
    logic signed [VAL_W-1:0]  coord_value;
    logic [LVL_W-1:0]         level;

    modport source (output valid, kind, point_index, coord_index, coord_value, level,
                    input ready);
    modport sink   (input valid, kind, point_index, coord_index, coord_value, level,
                    output ready);
endinterface

// ===== rtl/mcc_out_if.sv =====
// output channel of the concordance counter
`timescale 1ns / 1ps
interface mcc_out_if
    import mcc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CNT_W-1:0]  concordant_count;
    logic [PIDX_W-1:0] point_echo;
    logic [LVL_W-1:0]  level_echo;
    logic              compute_done;

    modport source (output valid, concordant_count, point_echo, level_echo, compute_done,
                    input ready);
    modport sink   (input valid, concordant_count, point_echo, level_echo, compute_done,
                    output ready);
endinterface

// ===== rtl/mcc_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps
module mcc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== rtl/multivariate_concordance_counter_top.sv =====
// top level of the multivariate concordance counter
// a load gives no result; a query reads and sums the discord counts of levels 0 to its level into the
//   output register, and skips the reads before the first compute or for a point beyond point_count
// compute: clears the whole discord store, then per row i reads its coordinates and discord counts,
//   compares each later point j and at the first discordant coordinate bumps that level for both points
// one transaction at a time; loads may follow each other every cycle
// reset (synchronous, active low) sets point_count 1024, dim_count 8, empties the output
//   register; a query before the first compute counts no discords
`timescale 1ns / 1ps
module multivariate_concordance_counter_top
    import mcc_pkg::*;
#(
    parameter int MAX_POINTS  = 1024,
    parameter int MAX_DIMS    = 8,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    mcc_in_if.sink                i_in,
    mcc_out_if.source             o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    // address and counter widths
    localparam int PW     = $clog2(MAX_POINTS);
    localparam int NW     = PW + 1;
    localparam int DW     = $clog2(MAX_DIMS);
    localparam int CW     = DW + 1;
    localparam int LEVELS = MAX_DIMS - 1;
    localparam int LW     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int CAW    = PW + DW;
    localparam int DAW    = PW + LW;

    t_state r_state, n_state;

    // configuration
    logic [PC_W-1:0] r_pc;
    logic [DC_W-1:0] r_dc;

    // compute sweep state
    logic [NW-1:0]          r_n, r_i, r_j;
    logic [CW-1:0]          r_d, r_col;
    logic                   r_swap;
    logic [LW-1:0]          r_lv;
    logic [DAW-1:0]         r_clr;
    logic [VALUE_WIDTH-1:0] r_ci  [MAX_DIMS];   // row i coordinates
    logic [CNT_W-1:0]       r_cnt [LEVELS];     // row i discord counts
    logic                   r_computed;

    // query state
    logic [PIDX_W-1:0] r_qp;
    logic [LW-1:0]     r_qlvl, r_t;
    logic [CNT_W-1:0]  r_acc;
    logic              r_is_q;

    // output register
    logic              r_ov;
    logic [CNT_W-1:0]  r_o_cnt;
    logic [PIDX_W-1:0] r_o_pt;
    logic [LVL_W-1:0]  r_o_lv;
    logic              r_o_done;

    // ram ports
    logic                   c_we;
    logic [CAW-1:0]         c_waddr, c_raddr;
    logic [VALUE_WIDTH-1:0] c_wdata, c_rdata;
    logic                   d_we;
    logic [DAW-1:0]         d_waddr, d_raddr;
    logic [CNT_W-1:0]       d_wdata, d_rdata;

    logic                         w_acc;
    logic [NW-1:0]                w_n;
    logic [CW-1:0]                w_d, w_top;
    logic [LW-1:0]                w_qlvl, w_lv;
    logic                         w_qhit, w_load_ok;
    logic [VALUE_WIDTH+VAL_W-1:0] w_ext;
    logic                         w_swap, w_greater, w_last_j, w_last_i;

    assign i_in.ready = (r_state == S_IDLE);
    assign w_acc      = i_in.valid && i_in.ready;

    // registers saturated into their legal ranges
    always_comb begin
        if (r_pc < 11'd2) begin
            w_n = NW'(2);
        end else if (32'(r_pc) > MAX_POINTS) begin
            w_n = NW'(MAX_POINTS);
        end else begin
            w_n = NW'(r_pc);
        end
        if (r_dc < 4'd2) begin
            w_d = CW'(2);
        end else if (32'(r_dc) > MAX_DIMS) begin
            w_d = CW'(MAX_DIMS);
        end else begin
            w_d = CW'(r_dc);
        end
    end

    // query level saturates at the top level in use
    assign w_top  = w_d - CW'(2);
    assign w_qlvl = (32'(i_in.level) > 32'(w_top)) ? LW'(w_top) : LW'(i_in.level);
    assign w_qhit = r_computed && (32'(i_in.point_index) < 32'(w_n));

    assign w_load_ok = (32'(i_in.point_index) < MAX_POINTS)
                    && (32'(i_in.coord_index) < MAX_DIMS);
    // low VALUE_WIDTH bits of the zero-extended coordinate
    assign w_ext     = {{VALUE_WIDTH{1'b0}}, i_in.coord_value};

    // pair ordering and discord test against row i
    assign w_swap    = $signed(c_rdata) < $signed(r_ci[0]);
    assign w_greater = r_swap ? ($signed(c_rdata) > $signed(r_ci[r_col[DW-1:0]]))
                              : ($signed(r_ci[r_col[DW-1:0]]) > $signed(c_rdata));
    assign w_lv      = LW'(r_col - CW'(1));
    assign w_last_j  = !(({1'b0, r_j} + (NW+1)'(1)) < {1'b0, r_n});
    assign w_last_i  = !(({1'b0, r_i} + (NW+1)'(2)) < {1'b0, r_n});

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    case (i_in.kind)
                        KIND_COMPUTE: n_state = S_CLR;
                        KIND_QUERY:   n_state = w_qhit ? S_Q_RD : S_DONE;
                        default:      n_state = S_IDLE;
                    endcase
                end
            end
            S_CLR:    if (&r_clr) n_state = S_ROW_RD;
            S_ROW_RD: if (r_col == CW'(MAX_DIMS)) n_state = S_J_RD;
            S_J_RD:   n_state = S_J_CMP;
            S_J_CMP: begin
                if (r_col != '0 && w_greater) begin
                    n_state = S_BUMP_WR;
                end else if (r_col != '0 && (r_col + CW'(1)) == r_d) begin
                    n_state = w_last_j ? S_ROW_WR : S_J_RD;
                end else begin
                    n_state = S_J_RD;
                end
            end
            S_BUMP_WR: n_state = w_last_j ? S_ROW_WR : S_J_RD;
            S_ROW_WR: begin
                if (r_col == CW'(LEVELS - 1)) begin
                    n_state = w_last_i ? S_DONE : S_ROW_RD;
                end
            end
            S_Q_RD:  n_state = S_Q_ACC;
            S_Q_ACC: n_state = (r_t == r_qlvl) ? S_DONE : S_Q_RD;
            S_DONE:  if (!r_ov || o_out.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // ram control
    always_comb begin
        c_we    = 1'b0;
        c_waddr = {PW'(i_in.point_index), DW'(i_in.coord_index)};
        c_wdata = w_ext[VALUE_WIDTH-1:0];
        c_raddr = {r_j[PW-1:0], r_col[DW-1:0]};
        d_we    = 1'b0;
        d_waddr = {r_j[PW-1:0], r_lv};
        d_wdata = d_rdata + CNT_W'(1);
        d_raddr = {r_j[PW-1:0], w_lv};
        case (r_state)
            S_IDLE: c_we = w_acc && (i_in.kind == KIND_LOAD) && w_load_ok;
            S_CLR: begin
                d_we    = 1'b1;
                d_waddr = r_clr;
                d_wdata = '0;
            end
            S_ROW_RD: begin
                c_raddr = {r_i[PW-1:0], r_col[DW-1:0]};
                d_raddr = {r_i[PW-1:0], LW'(r_col)};
            end
            S_BUMP_WR: d_we = 1'b1;
            S_ROW_WR: begin
                d_we    = 1'b1;
                d_waddr = {r_i[PW-1:0], LW'(r_col)};
                d_wdata = r_cnt[LW'(r_col)];
            end
            S_Q_RD: d_raddr = {PW'(r_qp), r_t};
            default: ;
        endcase
    end

    // coordinate store, point-major
    mcc_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(MAX_POINTS * (2 ** DW))) u_coord_ram (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (c_waddr),
        .i_wdata (c_wdata),
        .i_raddr (c_raddr),
        .o_rdata (c_rdata)
    );

    // discord counts, one row of levels per point
    mcc_ram #(.WIDTH(CNT_W), .DEPTH(MAX_POINTS * (2 ** LW))) u_discord_ram (
        .i_clk   (i_clk),
        .i_we    (d_we),
        .i_waddr (d_waddr),
        .i_wdata (d_wdata),
        .i_raddr (d_raddr),
        .o_rdata (d_rdata)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_pc       <= POINT_COUNT_RST;
            r_dc       <= DIM_COUNT_RST;
            r_computed <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_POINT_COUNT: r_pc <= i_cfg_data[PC_W-1:0];
                    REG_DIM_COUNT:   r_dc <= i_cfg_data[DC_W-1:0];
                    default: ;
                endcase
            end
            if (w_acc && i_in.kind == KIND_COMPUTE) begin
                r_computed <= 1'b1;
            end
            if (r_state == S_DONE && n_state == S_IDLE) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_clr  <= '0;
                r_n    <= w_n;
                r_d    <= w_d;
                r_qp   <= i_in.point_index;
                r_qlvl <= w_qlvl;
                r_t    <= '0;
                r_acc  <= '0;
                r_is_q <= (i_in.kind == KIND_QUERY);
            end
            S_CLR: begin
                r_clr <= r_clr + DAW'(1);
                r_i   <= '0;
                r_col <= '0;
            end
            S_ROW_RD: begin
                // read data arrives the cycle after its address
                if (r_col != '0) begin
                    r_ci[DW'(r_col - CW'(1))] <= c_rdata;
                    if (32'(r_col) <= LEVELS) begin
                        r_cnt[w_lv] <= d_rdata;
                    end
                end
                if (r_col == CW'(MAX_DIMS)) begin
                    r_col <= '0;
                    r_j   <= r_i + NW'(1);
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end
            S_J_CMP: begin
                if (r_col == '0) begin
                    r_swap <= w_swap;
                    r_col  <= CW'(1);
                end else if (w_greater) begin
                    r_cnt[w_lv] <= r_cnt[w_lv] + CNT_W'(1);
                    r_lv        <= w_lv;
                end else if ((r_col + CW'(1)) == r_d) begin
                    r_col <= '0;
                    r_j   <= r_j + NW'(1);
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end
            S_BUMP_WR: begin
                r_col <= '0;
                r_j   <= r_j + NW'(1);
            end
            S_ROW_WR: begin
                if (r_col == CW'(LEVELS - 1)) begin
                    r_col <= '0;
                    r_i   <= r_i + NW'(1);
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end
            S_Q_ACC: begin
                r_acc <= r_acc + d_rdata;
                r_t   <= r_t + LW'(1);
            end
            S_DONE: begin
                if (!r_ov || o_out.ready) begin
                    r_o_cnt  <= r_is_q ? (CNT_W'(w_n - NW'(1)) - r_acc) : '0;
                    r_o_pt   <= r_is_q ? r_qp : '0;
                    r_o_lv   <= r_is_q ? LVL_W'(r_qlvl) : '0;
                    r_o_done <= !r_is_q;
                end
            end
            default: ;
        endcase
    end

    assign o_out.valid            = r_ov;
    assign o_out.concordant_count = r_o_cnt;
    assign o_out.point_echo       = r_o_pt;
    assign o_out.level_echo       = r_o_lv;
    assign o_out.compute_done     = r_o_done;
endmodule

// ===== rtl/mcc_chk.sv =====
// port-level checks of the concordance counter and their binding
`timescale 1ns / 1ps
module mcc_chk
    import mcc_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic [KIND_W-1:0] i_in_kind,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [CNT_W-1:0]  i_out_cnt,
    input logic [PIDX_W-1:0] i_out_pt,
    input logic [LVL_W-1:0]  i_out_lv,
    input logic              i_out_done
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_cnt) && $stable(i_out_pt))
        else $error("result changed while stalled");

    a_done_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_done |-> i_out_cnt == '0 && i_out_pt == '0 && i_out_lv == '0)
        else $error("compute result carries data");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_kind == KIND_COMPUTE || i_in_kind == KIND_QUERY)
        |=> !i_in_ready)
        else $error("accepted while busy");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result after reset");
endmodule

bind multivariate_concordance_counter_top mcc_chk u_mcc_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_kind   (i_in.kind),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_cnt   (o_out.concordant_count),
    .i_out_pt    (o_out.point_echo),
    .i_out_lv    (o_out.level_echo),
    .i_out_done  (o_out.compute_done)
);
